// ===== hw/rtl/s5rp_pkg.sv =====
// ----------------------------------------------------------------------------
// s5rp_pkg
// Shared types and codes for the SOCKS5 request parser.
// ----------------------------------------------------------------------------
`default_nettype none

package s5rp_pkg;

    // Request field values
    localparam logic [7:0] SOCKS_VERSION = 8'd5;
    localparam logic [7:0] CMD_CONNECT   = 8'd1;
    localparam logic [7:0] RSV_BYTE      = 8'd0;
    localparam logic [7:0] ATYP_IPV4     = 8'd1;
    localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
    localparam logic [7:0] ATYP_IPV6     = 8'd4;
    localparam logic [7:0] IPV4_BYTES    = 8'd4;
    localparam logic [7:0] IPV6_BYTES    = 8'd16;

    // Status codes
    localparam logic [2:0] ST_BUSY    = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_GENERAL = 3'd2;
    localparam logic [2:0] ST_COMMAND = 3'd3;
    localparam logic [2:0] ST_ATYP    = 3'd4;

    // Address kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_IPV4   = 2'd1;
    localparam logic [1:0] KIND_DOMAIN = 2'd2;
    localparam logic [1:0] KIND_IPV6   = 2'd3;

    // Stream widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 1;

    // Parser phase, one-hot
    typedef enum logic [7:0] {
        PH_VERSION  = 8'b0000_0001,
        PH_COMMAND  = 8'b0000_0010,
        PH_RESERVED = 8'b0000_0100,
        PH_ATYP     = 8'b0000_1000,
        PH_ADDR     = 8'b0001_0000,
        PH_PORT     = 8'b0010_0000,
        PH_DONE     = 8'b0100_0000,
        PH_ERROR    = 8'b1000_0000
    } phase_t;

    // One result item
    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  addr_kind;
        logic [7:0]  addr_len;
        logic        addr_byte_valid;
        logic [7:0]  addr_byte;
        logic [7:0]  addr_index;
        logic [15:0] dest_port;
    } result_t;

endpackage : s5rp_pkg

`default_nettype wire

// ===== hw/rtl/s5rp_in_reg.sv =====
// ----------------------------------------------------------------------------
// s5rp_in_reg
// Input register: holds one request byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module s5rp_in_reg
    import s5rp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,   // [7:0] in_byte
    input  wire logic                 take,
    output      logic                 item_valid,
    output      logic [7:0]           item_byte
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;

    // Free when empty or when the held byte leaves this cycle
    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata[7:0];
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule : s5rp_in_reg

`default_nettype wire

// ===== hw/rtl/s5rp_core.sv =====
// ----------------------------------------------------------------------------
// s5rp_core
// Parser state and the per-byte update; gives the result for the byte taken.
// ----------------------------------------------------------------------------
`default_nettype none

module s5rp_core
    import s5rp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] in_byte,
    output      result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  err_reg, err_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  expected_reg, expected_next;
    logic [1:0]  kind_reg, kind_next;
    logic        high_seen_reg, high_seen_next;
    logic [15:0] port_reg, port_next;
    logic        bvalid;
    logic [7:0]  count_inc;

    assign count_inc = count_reg + 8'd1;

    // Next state for one byte
    always_comb begin
        phase_next     = phase_reg;
        err_next       = err_reg;
        count_next     = count_reg;
        expected_next  = expected_reg;
        kind_next      = kind_reg;
        high_seen_next = high_seen_reg;
        port_next      = port_reg;
        bvalid         = 1'b0;
        unique case (phase_reg)
            PH_VERSION: begin
                if (in_byte == SOCKS_VERSION) begin
                    phase_next = PH_COMMAND;
                end else begin
                    phase_next = PH_ERROR;
                    err_next   = ST_GENERAL;
                end
            end
            PH_COMMAND: begin
                if (in_byte == CMD_CONNECT) begin
                    phase_next = PH_RESERVED;
                end else begin
                    phase_next = PH_ERROR;
                    err_next   = ST_COMMAND;
                end
            end
            PH_RESERVED: begin
                if (in_byte == RSV_BYTE) begin
                    phase_next = PH_ATYP;
                end else begin
                    phase_next = PH_ERROR;
                    err_next   = ST_GENERAL;
                end
            end
            PH_ATYP: begin
                priority if (in_byte == ATYP_IPV4) begin
                    kind_next     = KIND_IPV4;
                    expected_next = IPV4_BYTES;
                    phase_next    = PH_ADDR;
                end else if (in_byte == ATYP_IPV6) begin
                    kind_next     = KIND_IPV6;
                    expected_next = IPV6_BYTES;
                    phase_next    = PH_ADDR;
                end else if (in_byte == ATYP_DOMAIN) begin
                    kind_next     = KIND_DOMAIN;
                    expected_next = 8'd0;
                    phase_next    = PH_ADDR;
                end else begin
                    phase_next = PH_ERROR;
                    err_next   = ST_ATYP;
                end
            end
            PH_ADDR: begin
                if (count_reg == 8'd0 && expected_reg == 8'd0) begin
                    // domain length byte; empty name skips to the port
                    if (in_byte == 8'd0) begin
                        phase_next = PH_PORT;
                    end else begin
                        expected_next = in_byte;
                    end
                end else begin
                    bvalid     = 1'b1;
                    count_next = count_inc;
                    if (count_inc == expected_reg) begin
                        phase_next = PH_PORT;
                    end
                end
            end
            PH_PORT: begin
                if (!high_seen_reg) begin
                    port_next      = {in_byte, 8'd0};
                    high_seen_next = 1'b1;
                end else begin
                    port_next  = port_reg + {8'd0, in_byte};
                    phase_next = PH_DONE;
                    err_next   = ST_OK;
                end
            end
            default: begin
                // finished or failed: byte ignored
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_VERSION;
            err_reg       <= ST_BUSY;
            count_reg     <= 8'd0;
            expected_reg  <= 8'd0;
            kind_reg      <= KIND_NONE;
            high_seen_reg <= 1'b0;
            port_reg      <= 16'd0;
        end else if (step) begin
            phase_reg     <= phase_next;
            err_reg       <= err_next;
            count_reg     <= count_next;
            expected_reg  <= expected_next;
            kind_reg      <= kind_next;
            high_seen_reg <= high_seen_next;
            port_reg      <= port_next;
        end
    end

    // Result seen after the update
    always_comb begin
        res.status          = err_next;
        res.addr_kind       = kind_next;
        res.addr_len        = expected_next;
        res.addr_byte_valid = bvalid;
        res.addr_byte       = bvalid ? in_byte : 8'd0;
        res.addr_index      = bvalid ? count_reg : 8'd0;
        res.dest_port       = port_next;
    end

endmodule : s5rp_core

`default_nettype wire

// ===== hw/rtl/s5rp_out_reg.sv =====
// ----------------------------------------------------------------------------
// s5rp_out_reg
// Result register driving the master stream.
// ----------------------------------------------------------------------------
`default_nettype none

module s5rp_out_reg
    import s5rp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire result_t               res,
    output      logic                  free,
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [OUT_DATA_W-1:0] m_tdata,
    output      logic [OUT_USER_W-1:0] m_tuser
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    // Space when empty or being drained now
    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (free) begin
            valid_next = push;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && free) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'd0, res_reg.dest_port, res_reg.addr_index, res_reg.addr_byte,
                       res_reg.addr_len, res_reg.addr_kind, res_reg.status};
    assign m_tuser  = res_reg.addr_byte_valid;

endmodule : s5rp_out_reg

`default_nettype wire

// ===== hw/rtl/socks5_request_parser.sv =====
// ----------------------------------------------------------------------------
// socks5_request_parser
// SOCKS5 CONNECT request parser, one request byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries the raw request, one byte per transaction in
//   s_tdata. For every byte the master stream gives one result transaction:
//   sticky status, address kind, expected address length, the port register
//   and, flagged by m_tuser, an address byte with its index in the address.
//   Address bytes are passed straight through rather than buffered.
//   An accepted byte passes through the input register and then the result
//   register. Throughput: one byte per cycle while the master side keeps up,
//   as the state update between the two registers is combinational.
//   Reset (aresetn low, synchronous) empties both registers and returns the
//   parser to the version byte with status in progress.
//   When m_tready is low the result register holds; the input register still
//   takes one further byte, after which s_tready drops until the master
//   side drains. Once success or a failure is reached further bytes are
//   taken and answered with the same status until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module socks5_request_parser
    import s5rp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] in_byte
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    // [2:0] status, [4:3] addr_kind, [12:5] addr_len, [20:13] addr_byte,
    // [28:21] addr_index, [44:29] dest_port, [47:45] zero
    output      logic [OUT_DATA_W-1:0] m_tdata,
    output      logic [OUT_USER_W-1:0] m_tuser    // [0] addr_byte_valid
);

    logic       item_valid;
    logic [7:0] item_byte;
    logic       out_free;
    logic       step;
    result_t    res;

    // Byte moves through the parser when the result register has room
    assign step = item_valid && out_free;

    s5rp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (step),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    s5rp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_byte (item_byte),
        .res     (res)
    );

    s5rp_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (step),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule : socks5_request_parser

`default_nettype wire
